FILE: hw/rtl/dirty_page_bitmap_tracker_top_macros.svh
// Assertion helpers used by the checker file of this block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef DIRTY_PAGE_BITMAP_TRACKER_TOP_MACROS_SVH
`define DIRTY_PAGE_BITMAP_TRACKER_TOP_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define DPBT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define DPBT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define DPBT_ASSERT_NXT_ALL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/dpbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dpbt_pkg;

  // Bitmap word geometry: one memory word holds the dirty bits of 64 pages.
  localparam int WORD_BITS     = 64;
  localparam int LOG_WORD_BITS = 6;

  // Most page indices a single list item may emit.
  localparam int LIST_LIMIT = 64;

  // Field widths of the ports.
  localparam int MEM_BYTES_W = 21;
  localparam int ADDR_W      = 32;
  localparam int LEN_W       = 32;
  localparam int PIDX_W      = 8;
  localparam int MAXC_W      = 7;
  localparam int TOTAL_W     = 9;

  // Tracked memory size after reset.
  localparam logic [MEM_BYTES_W-1:0] MEM_BYTES_RESET = 21'd1048576;

  // Item kinds.
  typedef enum logic [1:0] {
    KIND_MARK  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_TEST  = 2'd2,
    KIND_LIST  = 2'd3
  } kind_t;

  // Sequencer states.
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_MARK   = 7'b0000010,
    ST_RESP   = 7'b0000100,
    ST_TEST   = 7'b0001000,
    ST_LLOAD  = 7'b0010000,
    ST_LSCAN  = 7'b0100000,
    ST_LFLUSH = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dirty_page_bitmap_tracker_top.sv
// Dirty page bitmap tracker.
// Input channel (in_valid/in_ready) takes one item: kind selects mark range,
// clear all, test one page or list dirty pages. Output channel
// (out_valid/out_ready) returns result items; every result carries the dirty
// page total and last marks the final result of an item. memory_bytes, written
// through memory_bytes_we, sets the number of pages in use; the user must write
// it only while the block is idle, the block does not enforce this (PAGE_BYTES
// must be a power of two). The bitmap lives in a memory of 64-bit words, one
// word read per cycle. A mark item reads and writes back every word its range
// touches (4 words at most with the default 256 pages). A list item scans the
// words in use in order; each page it finds shows only after the next one is
// found or the list ends.
// One item is worked on at a time; in_ready rises again once the result sits
// in the output register, so the next item overlaps a stalled result.
// Reset clears the bitmap (per-word valid bits), the total, and restores the
// default memory size. A stall on out_ready holds the result and, when the
// sequencer has a further result, pauses it until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module dirty_page_bitmap_tracker_top
  import dpbt_pkg::*;
#(
  parameter int PAGE_BYTES = 4096,
  parameter int MAX_PAGES  = 256
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   memory_bytes_we,
  input  wire logic [MEM_BYTES_W-1:0] memory_bytes,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             kind,
  input  wire logic [ADDR_W-1:0]      addr,
  input  wire logic [LEN_W-1:0]       length,
  input  wire logic [PIDX_W-1:0]      page_index,
  input  wire logic [MAXC_W-1:0]      max_listed,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        page_dirty,
  output logic [7:0]                  listed_page,
  output logic                        listed_valid,
  output logic [TOTAL_W-1:0]          dirty_total,
  output logic                        last
);

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int NWORDS     = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW        = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int PW         = $clog2(MAX_PAGES);
  localparam int CW         = $clog2(MAX_PAGES + 1);
  localparam int SUMW       = MEM_BYTES_W + 1;

  localparam logic [WORD_BITS-1:0] ONES = '1;

  // Pages in use for a memory size: rounded up and capped.
  function automatic logic [CW-1:0] pages_of(input logic [MEM_BYTES_W-1:0] bytes);
    logic [SUMW-1:0] sum;
    logic [SUMW-1:0] n;
    sum = SUMW'(bytes) + SUMW'(PAGE_BYTES - 1);
    n   = sum >> PAGE_SHIFT;
    if (n > SUMW'(MAX_PAGES)) begin
      n = SUMW'(MAX_PAGES);
    end
    return CW'(n);
  endfunction

  // Word address that holds a page's bit.
  function automatic logic [WAW-1:0] word_of(input logic [PW-1:0] p);
    return WAW'(32'(p) >> LOG_WORD_BITS);
  endfunction

  // Number of set bits in one bitmap word.
  function automatic logic [LOG_WORD_BITS:0] popcount(input logic [WORD_BITS-1:0] v);
    logic [LOG_WORD_BITS:0] c;
    c = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      c = c + (LOG_WORD_BITS + 1)'(v[i]);
    end
    return c;
  endfunction

  // Registers.
  state_t                 state, state_next;
  logic [CW-1:0]          pages_used;
  logic [CW-1:0]          tally, tally_next;
  logic [WAW-1:0]         w, w_next;
  logic                   issue_done, issue_done_next;
  logic                   pend, pend_next;
  logic [WAW-1:0]         pend_addr, pend_addr_next;
  logic [PW-1:0]          start_pg, start_pg_next;
  logic [PW-1:0]          end_pg, end_pg_next;
  logic [WORD_BITS-1:0]   scan, scan_next;
  logic                   lst_valid, lst_valid_next;
  logic [PW-1:0]          lst_page, lst_page_next;
  logic [MAXC_W-1:0]      found_n, found_n_next;
  logic [MAXC_W-1:0]      max_n, max_n_next;
  logic [LOG_WORD_BITS-1:0] tst_idx, tst_idx_next;
  logic                   tst_ok, tst_ok_next;

  // Bitmap memory, its per-word valid bits and the registered read port.
  logic [WORD_BITS-1:0]   mem [NWORDS];
  logic [NWORDS-1:0]      vbits;
  logic [WORD_BITS-1:0]   rd_data;
  logic                   rd_vld;
  logic                   mem_re, mem_we, clear_all;
  logic [WAW-1:0]         mem_raddr, mem_waddr;
  logic [WORD_BITS-1:0]   mem_wdata;

  // Result emission.
  logic                   emit, emit_dirty, emit_lvalid, emit_last;
  logic [PW-1:0]          emit_page;
  logic                   out_free;

  // Combinational helpers.
  logic [WORD_BITS-1:0]   eff_word;
  logic [PW-1:0]          last_page;
  logic [WAW-1:0]         last_word;
  logic [ADDR_W:0]        addr_end;
  logic [ADDR_W-1:0]      mk_start;
  logic [ADDR_W:0]        mk_end;
  logic                   mk_none;
  logic [PW-1:0]          mk_end_pg;
  logic                   tst_in;
  logic [LOG_WORD_BITS-1:0] mk_lo, mk_hi;
  logic [WORD_BITS-1:0]   mk_mask;
  logic [WORD_BITS-1:0]   inuse_mask;
  logic [LOG_WORD_BITS-1:0] ffs;
  logic [PW-1:0]          found_pg;

  assign out_free  = !out_valid || out_ready;
  assign eff_word  = rd_vld ? rd_data : '0;
  assign last_page = PW'(pages_used - CW'(1));
  assign last_word = word_of(last_page);

  // Range of a mark item, computed without wraparound.
  assign addr_end  = {1'b0, addr} + {1'b0, length} - (ADDR_W + 1)'(1);
  assign mk_start  = addr >> PAGE_SHIFT;
  assign mk_end    = addr_end >> PAGE_SHIFT;
  assign mk_none   = (length == '0) || (pages_used == '0) ||
                     (mk_start >= ADDR_W'(pages_used));
  assign mk_end_pg = (mk_end >= (ADDR_W + 1)'(pages_used)) ? last_page : PW'(mk_end);

  assign tst_in    = 32'(page_index) < 32'(MAX_PAGES);

  // Bits of the word in flight that the mark range covers.
  assign mk_lo   = (pend_addr == word_of(start_pg)) ? start_pg[LOG_WORD_BITS-1:0] : '0;
  assign mk_hi   = (pend_addr == word_of(end_pg)) ? end_pg[LOG_WORD_BITS-1:0] : '1;
  assign mk_mask = (ONES << mk_lo) & (ONES >> (LOG_WORD_BITS'(WORD_BITS - 1) - mk_hi));

  // Pages of the current list word that are in use.
  assign inuse_mask = (w == last_word) ?
                      (ONES >> (LOG_WORD_BITS'(WORD_BITS - 1) -
                                last_page[LOG_WORD_BITS-1:0])) : ONES;

  // Lowest set bit of the scan word.
  always_comb begin
    ffs = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (scan[i]) begin
        ffs = LOG_WORD_BITS'(i);
      end
    end
  end

  assign found_pg = PW'((32'(w) << LOG_WORD_BITS) | 32'(ffs));

  // Sequencer.
  always_comb begin
    state_next      = state;
    tally_next      = tally;
    w_next          = w;
    issue_done_next = issue_done;
    pend_next       = pend;
    pend_addr_next  = pend_addr;
    start_pg_next   = start_pg;
    end_pg_next     = end_pg;
    scan_next       = scan;
    lst_valid_next  = lst_valid;
    lst_page_next   = lst_page;
    found_n_next    = found_n;
    max_n_next      = max_n;
    tst_idx_next    = tst_idx;
    tst_ok_next     = tst_ok;
    in_ready        = 1'b0;
    mem_re          = 1'b0;
    mem_raddr       = '0;
    mem_we          = 1'b0;
    mem_waddr       = pend_addr;
    mem_wdata       = eff_word | mk_mask;
    clear_all       = 1'b0;
    emit            = 1'b0;
    emit_dirty      = 1'b0;
    emit_page       = '0;
    emit_lvalid     = 1'b0;
    emit_last       = 1'b1;

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (kind_t'(kind))
            KIND_MARK: begin
              if (mk_none) begin
                state_next = ST_RESP;
              end else begin
                start_pg_next   = PW'(mk_start);
                end_pg_next     = mk_end_pg;
                w_next          = word_of(PW'(mk_start));
                issue_done_next = 1'b0;
                pend_next       = 1'b0;
                state_next      = ST_MARK;
              end
            end
            KIND_CLEAR: begin
              clear_all  = 1'b1;
              tally_next = '0;
              state_next = ST_RESP;
            end
            KIND_TEST: begin
              mem_re       = 1'b1;
              mem_raddr    = tst_in ? word_of(PW'(page_index)) : '0;
              tst_idx_next = page_index[LOG_WORD_BITS-1:0];
              tst_ok_next  = tst_in;
              state_next   = ST_TEST;
            end
            KIND_LIST: begin
              max_n_next     = (max_listed > MAXC_W'(LIST_LIMIT)) ?
                               MAXC_W'(LIST_LIMIT) : max_listed;
              found_n_next   = '0;
              lst_valid_next = 1'b0;
              w_next         = '0;
              if ((pages_used == '0) || (max_listed == '0)) begin
                state_next = ST_LFLUSH;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                state_next = ST_LLOAD;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end

      // Read one word per cycle; the word read in the previous cycle is merged and
      // written back, and the newly set bits are added to the total.
      ST_MARK: begin
        if (!issue_done) begin
          mem_re          = 1'b1;
          mem_raddr       = w;
          w_next          = w + WAW'(1);
          issue_done_next = (w == word_of(end_pg));
        end
        pend_next      = !issue_done;
        pend_addr_next = w;
        if (pend) begin
          mem_we     = 1'b1;
          tally_next = tally + CW'(popcount(mk_mask & ~eff_word));
          if (issue_done) begin
            state_next = ST_RESP;
          end
        end
      end

      ST_RESP: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end

      ST_TEST: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_dirty = tst_ok & eff_word[tst_idx];
          state_next = ST_IDLE;
        end
      end

      ST_LLOAD: begin
        scan_next  = eff_word & inuse_mask;
        state_next = ST_LSCAN;
      end

      // The found page waits in lst_page until the next one is found, so the
      // final result of the item can carry last.
      ST_LSCAN: begin
        if (scan != '0) begin
          if (!lst_valid || out_free) begin
            if (lst_valid) begin
              emit        = 1'b1;
              emit_page   = lst_page;
              emit_lvalid = 1'b1;
              emit_last   = 1'b0;
            end
            lst_valid_next = 1'b1;
            lst_page_next  = found_pg;
            scan_next      = scan & ~(WORD_BITS'(1) << ffs);
            found_n_next   = found_n + MAXC_W'(1);
            if (found_n + MAXC_W'(1) == max_n) begin
              state_next = ST_LFLUSH;
            end
          end
        end else if (w == last_word) begin
          state_next = ST_LFLUSH;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = w + WAW'(1);
          w_next     = w + WAW'(1);
          state_next = ST_LLOAD;
        end
      end

      ST_LFLUSH: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_page   = lst_valid ? lst_page : '0;
          emit_lvalid = lst_valid;
          state_next  = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pages_used <= pages_of(MEM_BYTES_RESET);
      tally      <= '0;
      vbits      <= '0;
      rd_vld     <= 1'b0;
      out_valid  <= 1'b0;
      issue_done <= 1'b0;
      pend       <= 1'b0;
      lst_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      tally      <= tally_next;
      issue_done <= issue_done_next;
      pend       <= pend_next;
      lst_valid  <= lst_valid_next;
      if (memory_bytes_we) begin
        pages_used <= pages_of(memory_bytes);
      end
      if (mem_re) begin
        rd_vld <= vbits[mem_raddr];
      end
      if (clear_all) begin
        vbits <= '0;
      end else if (mem_we) begin
        vbits[mem_waddr] <= 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    w         <= w_next;
    pend_addr <= pend_addr_next;
    start_pg  <= start_pg_next;
    end_pg    <= end_pg_next;
    scan      <= scan_next;
    lst_page  <= lst_page_next;
    found_n   <= found_n_next;
    max_n     <= max_n_next;
    tst_idx   <= tst_idx_next;
    tst_ok    <= tst_ok_next;
    if (emit) begin
      page_dirty   <= emit_dirty;
      listed_page  <= 8'(emit_page);
      listed_valid <= emit_lvalid;
      dirty_total  <= TOTAL_W'(tally);
      last         <= emit_last;
    end
  end

  // Bitmap memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dpbt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "dirty_page_bitmap_tracker_top_macros.svh"

module dpbt_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       page_dirty,
  input wire logic [7:0] listed_page,
  input wire logic       listed_valid,
  input wire logic [8:0] dirty_total,
  input wire logic       last
);

  // All result fields packed for the stall check.
  logic [19:0] out_word;
  assign out_word = {page_dirty, listed_page, listed_valid, dirty_total, last};

  // A stalled result item stays put.
  `DPBT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "result changed while stalled")

  // Reset leaves no result and an open input.
  `DPBT_ASSERT_NXT_ALL(a_reset, rst, in_ready && !out_valid, "reset did not empty the block")

  // Results without a listed page are the single, final result of their item.
  `DPBT_ASSERT_IMP(a_no_list, out_valid && !listed_valid, (listed_page == 8'd0) && last, "unlisted result malformed")

  // A dirty test answer is never part of a list.
  `DPBT_ASSERT_IMP(a_test, out_valid && page_dirty, last && !listed_valid, "test result malformed")

endmodule

bind dirty_page_bitmap_tracker_top dpbt_checker u_dpbt_checker (.*);

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dpbt_pkg::*;

  localparam int PAGE_BYTES   = 4096;
  localparam int PAGE_LIMIT   = 256;
  localparam int SETTLE_TICKS = 16;
  localparam int HOLD_TICKS   = 400;
  localparam int CYCLE_LIMIT  = 8000000;

  // One result item as the block reports it.
  typedef struct packed {
    logic               page_dirty;
    logic [7:0]         listed_page;
    logic               listed_valid;
    logic [TOTAL_W-1:0] dirty_total;
    logic               last;
  } page_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   memory_bytes_we = 1'b0;
  logic [MEM_BYTES_W-1:0] memory_bytes = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             kind = KIND_MARK;
  logic [ADDR_W-1:0]      addr = '0;
  logic [LEN_W-1:0]       length = '0;
  logic [PIDX_W-1:0]      page_index = '0;
  logic [MAXC_W-1:0]      max_listed = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   page_dirty;
  logic [7:0]             listed_page;
  logic                   listed_valid;
  logic [TOTAL_W-1:0]     dirty_total;
  logic                   last;

  // Shadow copy of the bitmap, the dirty count and the memory size register.
  logic [PAGE_LIMIT-1:0]  shadow_dirty = '0;
  int unsigned            shadow_tally = 0;
  logic [MEM_BYTES_W-1:0] shadow_mem_bytes = MEM_BYTES_RESET;

  page_result_t awaited_results[$];

  int  error_count = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  size_writes = 0;
  int  tick_count = 0;
  bit  tx_idle = 1'b1;
  bit  rx_idle = 1'b1;
  bit  long_hold_req = 1'b0;
  int  rx_stall_left = 0;

  dirty_page_bitmap_tracker_top #(
    .PAGE_BYTES(PAGE_BYTES),
    .MAX_PAGES (PAGE_LIMIT)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .memory_bytes_we(memory_bytes_we),
    .memory_bytes   (memory_bytes),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .addr           (addr),
    .length         (length),
    .page_index     (page_index),
    .max_listed     (max_listed),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .page_dirty     (page_dirty),
    .listed_page    (listed_page),
    .listed_valid   (listed_valid),
    .dirty_total    (dirty_total),
    .last           (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Number of pages covered by the current memory size, capped at the store size.
  function automatic int pages_in_use();
    logic [63:0] n;
    n = ({43'd0, shadow_mem_bytes} + PAGE_BYTES - 1) / PAGE_BYTES;
    if (n > PAGE_LIMIT) n = 64'(PAGE_LIMIT);
    return int'(n);
  endfunction

  function automatic page_result_t result_of(input logic pd, input logic [7:0] lp,
                                             input logic lv, input logic lst);
    page_result_t r;
    r.page_dirty   = pd;
    r.listed_page  = lp;
    r.listed_valid = lv;
    r.dirty_total  = shadow_tally[TOTAL_W-1:0];
    r.last         = lst;
    return r;
  endfunction

  // Applies one accepted item to the shadow bitmap and queues the results it causes.
  task automatic model_page_item(input kind_t k, input logic [31:0] a, input logic [31:0] len,
                                 input logic [7:0] pidx, input logic [6:0] mcount);
    int          npages;
    int          limit;
    logic [63:0] first_pg;
    logic [63:0] last_pg;
    int          found[$];
    npages = pages_in_use();
    case (k)
      KIND_MARK: begin
        if (len != 0 && npages != 0) begin
          first_pg = {32'd0, a} / PAGE_BYTES;
          last_pg  = ({32'd0, a} + {32'd0, len} - 64'd1) / PAGE_BYTES;
          if (first_pg < npages) begin
            if (last_pg >= npages) last_pg = 64'(npages - 1);
            for (int p = int'(first_pg); p <= int'(last_pg); p++) begin
              if (!shadow_dirty[p]) begin
                shadow_dirty[p] = 1'b1;
                shadow_tally++;
              end
            end
          end
        end
        awaited_results.push_back(result_of(1'b0, 8'd0, 1'b0, 1'b1));
      end
      KIND_CLEAR: begin
        shadow_dirty = '0;
        shadow_tally = 0;
        awaited_results.push_back(result_of(1'b0, 8'd0, 1'b0, 1'b1));
      end
      KIND_TEST: begin
        awaited_results.push_back(result_of(shadow_dirty[pidx], 8'd0, 1'b0, 1'b1));
      end
      default: begin
        limit = (mcount > LIST_LIMIT) ? LIST_LIMIT : int'(mcount);
        for (int p = 0; p < npages && found.size() < limit; p++) begin
          if (shadow_dirty[p]) found.push_back(p);
        end
        if (found.size() == 0) begin
          awaited_results.push_back(result_of(1'b0, 8'd0, 1'b0, 1'b1));
        end else begin
          foreach (found[i]) begin
            awaited_results.push_back(result_of(1'b0, found[i][7:0], 1'b1,
                                                i == found.size() - 1));
          end
        end
      end
    endcase
  endtask

  // Sender gap: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    if (!tx_idle || $urandom_range(0, 2) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(15, 50);
    return $urandom_range(1, 3);
  endfunction

  // Offers one item and waits until the block takes it.
  task automatic send_item(input kind_t k, input logic [31:0] a, input logic [31:0] len,
                           input logic [7:0] pidx, input logic [6:0] mcount);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    addr       <= a;
    length     <= len;
    page_index <= pidx;
    max_listed <= mcount;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model_page_item(k, a, len, pidx, mcount);
    items_sent++;
  endtask

  // Stops offering items until every awaited result has come, then lets the block settle.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic set_memory_bytes(input logic [MEM_BYTES_W-1:0] value);
    wait_drain();
    memory_bytes_we <= 1'b1;
    memory_bytes    <= value;
    @(posedge clk);
    memory_bytes_we <= 1'b0;
    shadow_mem_bytes = value;
    size_writes++;
  endtask

  // Receiver: random stalls, mostly short, plus one long hold on request.
  always @(posedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      rx_stall_left = HOLD_TICKS;
    end
    if (rx_stall_left > 0) begin
      out_ready <= 1'b0;
      rx_stall_left--;
    end else if (rx_idle && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      rx_stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic void flag_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Compares every accepted result with the oldest awaited one.
  always @(posedge clk) begin
    page_result_t want;
    page_result_t got;
    if (!rst && out_valid && out_ready) begin
      got = '{page_dirty, listed_page, listed_valid, dirty_total, last};
      results_seen++;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        error_count++;
      end else if (^got === 1'bx) begin
        want = awaited_results.pop_front();
        $display("%0t: unknown bits in result, expected %h, actual %h", $time, want, got);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        flag_field("page_dirty", want.page_dirty, got.page_dirty);
        flag_field("listed_page", want.listed_page, got.listed_page);
        flag_field("listed_valid", want.listed_valid, got.listed_valid);
        flag_field("dirty_total", want.dirty_total, got.dirty_total);
        flag_field("last", want.last, got.last);
      end
    end
  end

  // Timeout guard.
  initial begin
    while (tick_count < CYCLE_LIMIT) begin
      @(posedge clk);
      tick_count++;
    end
    $display("%0t: timeout with %0d results outstanding", $time, awaited_results.size());
    $display("TB_ERROR");
    $finish;
  end

  // Fresh store: nothing dirty, nothing to list, an empty mark changes nothing.
  task automatic test_fresh_store();
    send_item(KIND_TEST, 32'd0, 32'd0, 8'd0, 7'd0);
    send_item(KIND_TEST, 32'd0, 32'd0, 8'd255, 7'd0);
    send_item(KIND_LIST, 32'd0, 32'd0, 8'd0, 7'd64);
    send_item(KIND_MARK, 32'd0, 32'd0, 8'd0, 7'd0);
  endtask

  // Range edges, wraparound past the top of the address space, list caps and clear.
  task automatic test_mark_edges();
    send_item(KIND_MARK, 32'd0, 32'd1, 8'd0, 7'd0);
    send_item(KIND_MARK, 32'd4095, 32'd2, 8'd0, 7'd0);
    send_item(KIND_MARK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 7'h7F);
    send_item(KIND_MARK, 32'h000F_FFFF, 32'd1, 8'd0, 7'd0);
    send_item(KIND_TEST, 32'd0, 32'd0, 8'd1, 7'd0);
    send_item(KIND_TEST, 32'd0, 32'd0, 8'd2, 7'd0);
    send_item(KIND_LIST, 32'd0, 32'd0, 8'd0, 7'd0);
    send_item(KIND_MARK, 32'h0001_0000, 32'hFFFF_FFFF, 8'd0, 7'd0);
    send_item(KIND_LIST, 32'd0, 32'd0, 8'd0, 7'd127);
    send_item(KIND_LIST, 32'd0, 32'd0, 8'd0, 7'd3);
    send_item(KIND_CLEAR, 32'd0, 32'd0, 8'd0, 7'd0);
    send_item(KIND_LIST, 32'd0, 32'd0, 8'd0, 7'd64);
  endtask

  // Size changes keep the store; pages beyond the size still count but are never listed.
  task automatic test_size_extremes();
    send_item(KIND_MARK, 32'd200 * PAGE_BYTES, 32'd4 * PAGE_BYTES, 8'd0, 7'd0);
    set_memory_bytes(21'd40000);
    send_item(KIND_TEST, 32'd0, 32'd0, 8'd201, 7'd0);
    send_item(KIND_MARK, 32'd0, 32'hFFFF_FFFF, 8'd0, 7'd0);
    send_item(KIND_LIST, 32'd0, 32'd0, 8'd0, 7'd64);
    set_memory_bytes(21'd0);
    send_item(KIND_CLEAR, 32'd0, 32'd0, 8'd0, 7'd0);
    send_item(KIND_MARK, 32'd0, 32'd100, 8'd0, 7'd0);
    send_item(KIND_LIST, 32'd0, 32'd0, 8'd0, 7'd64);
    set_memory_bytes(21'd1);
    send_item(KIND_MARK, 32'd0, 32'hFFFF_FFFF, 8'd0, 7'd0);
    send_item(KIND_LIST, 32'd0, 32'd0, 8'd0, 7'd64);
    set_memory_bytes(MEM_BYTES_RESET);
  endtask

  // Random item mix: mostly ranges inside memory, some noise anywhere in the address space.
  task automatic send_random_item();
    int          pick;
    int          npages;
    logic [31:0] a;
    logic [31:0] len;
    logic [7:0]  pidx;
    logic [6:0]  mcount;
    npages = pages_in_use();
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 85) begin
      a = $urandom_range(0, (shadow_mem_bytes == 0) ? 0 : shadow_mem_bytes - 1);
    end else begin
      a = $urandom;
    end
    case ($urandom_range(0, 9))
      0:       len = 32'd0;
      1, 2:    len = $urandom_range(1, 300000);
      3:       len = $urandom;
      default: len = $urandom_range(1, 8192);
    endcase
    if (npages > 0 && $urandom_range(0, 1) == 0) pidx = PIDX_W'($urandom_range(0, npages - 1));
    else pidx = PIDX_W'($urandom_range(0, 255));
    mcount = MAXC_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) :
                                                   $urandom_range(0, 10));
    if (pick < 50) send_item(KIND_MARK, a, len, pidx, mcount);
    else if (pick < 54) send_item(KIND_CLEAR, a, len, pidx, mcount);
    else if (pick < 80) send_item(KIND_TEST, a, len, pidx, mcount);
    else send_item(KIND_LIST, a, len, pidx, mcount);
  endtask

  task automatic test_random_traffic(input int count, input logic [MEM_BYTES_W-1:0] mem_size,
                                     input bit with_idle);
    set_memory_bytes(mem_size);
    tx_idle = with_idle;
    rx_idle = with_idle;
    repeat (count) send_random_item();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // Long receiver hold while the sender keeps offering items back to back.
  task automatic test_output_hold();
    tx_idle = 1'b0;
    long_hold_req = 1'b1;
    repeat (24) send_random_item();
    tx_idle = 1'b1;
    wait_drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_fresh_store();
    test_mark_edges();
    test_size_extremes();
    test_random_traffic(110, MEM_BYTES_RESET, 1'b1);
    test_random_traffic(100, MEM_BYTES_W'($urandom_range(40961, 1048575)), 1'b0);
    test_output_hold();
    test_random_traffic(90, MEM_BYTES_W'($urandom_range(1, 262143)), 1'b1);
    test_random_traffic(80, 21'd1048575, 1'b1);
    wait_drain();
    repeat (40) @(posedge clk);
    $display("Sent %0d items and checked %0d results over %0d memory size writes,",
             items_sent, results_seen, size_writes);
    $display("including zero, one byte and full size memory and a long output hold.");
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: dirty_page_bitmap_tracker_top.f
+incdir+hw/rtl
hw/rtl/dpbt_pkg.sv
hw/rtl/dirty_page_bitmap_tracker_top.sv
hw/rtl/dpbt_checker.sv
verif/tb_top.sv
